@@ sv/atzsd_pkg.sv @@
// Shared types, constants and tables for the tilt zone and shake detector.
package atzsd_pkg;

  localparam int SQ_STEPS     = 3;
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int CORD_W       = 44;
  localparam int ANG_W        = 29;
  localparam int FRAC_W       = 16;

  localparam logic [15:0] ONE_G = 16'd8192;

  localparam logic [2:0] TZ_FLAT   = 3'd0;
  localparam logic [2:0] TZ_FACEDN = 3'd1;
  localparam logic [2:0] TZ_RIGHT  = 3'd2;
  localparam logic [2:0] TZ_LEFT   = 3'd3;
  localparam logic [2:0] TZ_FWD    = 3'd4;
  localparam logic [2:0] TZ_BACK   = 3'd5;

  localparam logic [2:0] REG_VAR_THR   = 3'd0;
  localparam logic [2:0] REG_COOLDOWN  = 3'd1;
  localparam logic [2:0] REG_ROLL_LIM  = 3'd2;
  localparam logic [2:0] REG_PITCH_LIM = 3'd3;
  localparam logic [2:0] REG_FACEDOWN  = 3'd4;
  localparam logic [2:0] REG_ACT_MARG  = 3'd5;

  localparam logic [31:0]        RST_VAR_THR   = 32'd23488102;
  localparam logic [15:0]        RST_COOLDOWN  = 16'd1000;
  localparam logic [10:0]        RST_ROLL_LIM  = 11'd450;
  localparam logic [9:0]         RST_PITCH_LIM = 10'd300;
  localparam logic signed [15:0] RST_FACEDOWN  = -16'sd6553;
  localparam logic [15:0]        RST_ACT_MARG  = 16'd2457;

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(900 * 65536);
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(1800 * 65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_SQRT,
    ST_CORD,
    ST_WRITE,
    ST_SWEEP,
    ST_PROD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic cap;
    logic sq_en;
    logic sqrt_load;
    logic sqrt_step;
    logic cord_load;
    logic cord_step;
    logic win_wr;
    logic acc_clr;
    logic rd_en;
    logic acc_en;
    logic prod_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

  // atan(2^-i) in tenths of a degree, 16 fractional bits
  function automatic logic signed [ANG_W-1:0] atan_lut(logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = ANG_W'(29491200);
      5'd1:  v = ANG_W'(17409672);
      5'd2:  v = ANG_W'(9198793);
      5'd3:  v = ANG_W'(4669451);
      5'd4:  v = ANG_W'(2343786);
      5'd5:  v = ANG_W'(1173036);
      5'd6:  v = ANG_W'(586661);
      5'd7:  v = ANG_W'(293348);
      5'd8:  v = ANG_W'(146676);
      5'd9:  v = ANG_W'(73339);
      5'd10: v = ANG_W'(36669);
      5'd11: v = ANG_W'(18335);
      5'd12: v = ANG_W'(9167);
      5'd13: v = ANG_W'(4584);
      5'd14: v = ANG_W'(2292);
      5'd15: v = ANG_W'(1146);
      5'd16: v = ANG_W'(573);
      5'd17: v = ANG_W'(286);
      5'd18: v = ANG_W'(143);
      5'd19: v = ANG_W'(72);
      5'd20: v = ANG_W'(36);
      5'd21: v = ANG_W'(18);
      5'd22: v = ANG_W'(9);
      5'd23: v = ANG_W'(4);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/atzsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module atzsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/atzsd_sqrt.sv @@
// Bit-serial floor square root of a 64-bit value, two radicand bits per step.
module atzsd_sqrt (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  logic [63:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [34:0] rem_n, trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_n  = {rem_q[32:0], rad_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    if (load_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (step_i) begin
      rad_d = {rad_q[61:0], 2'b00};
      if (rem_n >= trial) begin
        rem_d  = 34'(rem_n - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_n[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

@@ sv/atzsd_cordic.sv @@
// One vectoring CORDIC lane: angle of (x, y), one micro-rotation per step.
module atzsd_cordic
  import atzsd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     step_i,
  input  logic [4:0]               shift_i,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  output logic signed [ANG_W-1:0]  z_o
);

  logic signed [CORD_W-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ANG_W-1:0]  z_q, z_d, at;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    dx  = x_q >>> shift_i;
    dy  = y_q >>> shift_i;
    at  = atan_lut(shift_i);
    if (load_i) begin
      x_d = x_i;
      y_d = y_i;
      z_d = '0;
      if (y_i == '0) begin
        if (x_i < 0) z_d = ANG_180;
      end else if (x_i <= 0) begin
        // pre-rotate into the right half plane
        if (y_i > 0) begin
          x_d = y_i;
          y_d = -x_i;
          z_d = ANG_90;
        end else begin
          x_d = -y_i;
          y_d = x_i;
          z_d = -ANG_90;
        end
      end
    end else if (step_i && (y_q != '0)) begin
      if (y_q > 0) begin
        x_d = x_q + dy;
        y_d = y_q - dx;
        z_d = z_q + at;
      end else begin
        x_d = x_q - dy;
        y_d = y_q + dx;
        z_d = z_q - at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign z_o = z_q;

endmodule

@@ sv/atzsd_dp.sv @@
// Datapath: squares, square roots, CORDIC lanes, magnitude window and result register.
module atzsd_dp
  import atzsd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8,
  parameter int CNT_W        = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [CNT_W-1:0] cnt_i,
  output status_t          status_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic [79:0]      in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      out_data_o
);

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int S1W = 16 + AW;
  localparam int S2W = 32 + AW;
  localparam int VW  = 32 + 2 * AW;
  localparam int NN  = WINDOW_DEPTH * WINDOW_DEPTH;

  // configuration
  logic [31:0]        thr_q;
  logic [15:0]        cool_q;
  logic [10:0]        rlim_q;
  logic [9:0]         plim_q;
  logic signed [15:0] fdl_q;
  logic [15:0]        marg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= RST_VAR_THR;
      cool_q <= RST_COOLDOWN;
      rlim_q <= RST_ROLL_LIM;
      plim_q <= RST_PITCH_LIM;
      fdl_q  <= RST_FACEDOWN;
      marg_q <= RST_ACT_MARG;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VAR_THR:   thr_q  <= cfg_data_i;
        REG_COOLDOWN:  cool_q <= cfg_data_i[15:0];
        REG_ROLL_LIM:  rlim_q <= cfg_data_i[10:0];
        REG_PITCH_LIM: plim_q <= cfg_data_i[9:0];
        REG_FACEDOWN:  fdl_q  <= signed'(cfg_data_i[15:0]);
        REG_ACT_MARG:  marg_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // captured sample
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [31:0]        tm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      ax_q <= signed'(in_data_i[15:0]);
      ay_q <= signed'(in_data_i[31:16]);
      az_q <= signed'(in_data_i[47:32]);
      tm_q <= in_data_i[79:48];
    end
  end

  // squares through one shared multiplier
  logic signed [15:0] sq_op;
  logic signed [31:0] sq_prod;
  logic [30:0]        sqx_q, sqy_q, sqz_q;
  logic [31:0]        yz2, magsq;

  always_comb begin
    case (cnt_i[1:0])
      2'd0:    sq_op = ax_q;
      2'd1:    sq_op = ay_q;
      default: sq_op = az_q;
    endcase
    sq_prod = sq_op * sq_op;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      case (cnt_i[1:0])
        2'd0:    sqx_q <= sq_prod[30:0];
        2'd1:    sqy_q <= sq_prod[30:0];
        default: sqz_q <= sq_prod[30:0];
      endcase
    end
  end

  assign yz2   = 32'(sqy_q) + 32'(sqz_q);
  assign magsq = 32'(sqx_q) + yz2;

  logic [31:0] yz_root, mag_root;

  atzsd_sqrt u_sqrt_yz (
    .clk_i  (clk_i),
    .load_i (cmd_i.sqrt_load),
    .step_i (cmd_i.sqrt_step),
    .rad_i  ({yz2, 32'd0}),
    .root_o (yz_root)
  );

  atzsd_sqrt u_sqrt_mag (
    .clk_i  (clk_i),
    .load_i (cmd_i.sqrt_load),
    .step_i (cmd_i.sqrt_step),
    .rad_i  ({32'd0, magsq}),
    .root_o (mag_root)
  );

  // CORDIC operands
  logic signed [16:0]       neg_ax;
  logic signed [CORD_W-1:0] roll_x, roll_y, pitch_x, pitch_y;
  logic signed [ANG_W-1:0]  roll_z, pitch_z;

  assign neg_ax  = -{ax_q[15], ax_q};
  assign roll_x  = {{(CORD_W-40){az_q[15]}}, az_q, 24'd0};
  assign roll_y  = {{(CORD_W-40){ay_q[15]}}, ay_q, 24'd0};
  assign pitch_y = {{(CORD_W-41){neg_ax[16]}}, neg_ax, 24'd0};
  assign pitch_x = {{(CORD_W-40){1'b0}}, yz_root, 8'd0};

  atzsd_cordic u_cord_roll (
    .clk_i   (clk_i),
    .load_i  (cmd_i.cord_load),
    .step_i  (cmd_i.cord_step),
    .shift_i (cnt_i[4:0]),
    .x_i     (roll_x),
    .y_i     (roll_y),
    .z_o     (roll_z)
  );

  atzsd_cordic u_cord_pitch (
    .clk_i   (clk_i),
    .load_i  (cmd_i.cord_load),
    .step_i  (cmd_i.cord_step),
    .shift_i (cnt_i[4:0]),
    .x_i     (pitch_x),
    .y_i     (pitch_y),
    .z_o     (pitch_z)
  );

  // magnitude window
  logic [15:0]             mag;
  logic [AW-1:0]           wptr_q;
  logic [WINDOW_DEPTH-1:0] vld_q;
  logic                    rd_vld_q;
  logic [15:0]             rd_data, win_m;
  logic [S1W-1:0]          s1_q;
  logic [S2W-1:0]          s2_q;
  logic [31:0]             m_sq;

  assign mag = mag_root[15:0];

  atzsd_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW_DEPTH)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.win_wr),
    .waddr_i (wptr_q),
    .wdata_i (mag),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cnt_i[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      vld_q  <= '0;
    end else if (cmd_i.win_wr) begin
      vld_q[wptr_q] <= 1'b1;
      if (wptr_q == AW'(WINDOW_DEPTH - 1)) wptr_q <= '0;
      else wptr_q <= wptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_vld_q <= vld_q[cnt_i[AW-1:0]];
  end

  // entries never written count as zero
  assign win_m = rd_vld_q ? rd_data : 16'd0;
  assign m_sq  = win_m * win_m;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (cmd_i.acc_en) begin
      s1_q <= s1_q + S1W'(win_m);
      s2_q <= s2_q + S2W'(m_sq);
    end
  end

  logic [VW-1:0] ns2_q, s1sq_q, rhs_q, lhs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      ns2_q  <= VW'(s2_q) * VW'(WINDOW_DEPTH);
      s1sq_q <= VW'(s1_q) * VW'(s1_q);
      rhs_q  <= VW'(thr_q) * VW'(NN);
    end
  end

  assign lhs = ns2_q - s1sq_q;

  // result
  function automatic logic signed [12:0] to_tenths(logic signed [ANG_W-1:0] z,
                                                  logic signed [12:0] lim);
    logic signed [ANG_W-1:0] sh;
    logic signed [12:0]      t;
    sh = z >>> FRAC_W;
    t  = sh[12:0];
    if (z[ANG_W-1] && (z[FRAC_W-1:0] != '0)) t = t + 13'sd1;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t;
  endfunction

  logic signed [ANG_W-1:0] rl, pl;
  logic signed [12:0]      roll_t, pitch_t;
  logic [2:0]              zone;
  logic [31:0]             since;
  logic                    shake;
  logic [15:0]             dev;
  logic                    active;
  logic [31:0]             last_q;

  assign rl      = {2'b00, rlim_q, 16'd0};
  assign pl      = {3'b000, plim_q, 16'd0};
  assign roll_t  = to_tenths(roll_z, 13'sd1800);
  assign pitch_t = to_tenths(pitch_z, 13'sd900);
  assign since   = tm_q - last_q;
  assign shake   = (lhs > rhs_q) && (since > 32'(cool_q));
  assign dev     = (mag >= ONE_G) ? (mag - ONE_G) : (ONE_G - mag);
  assign active  = dev > marg_q;

  always_comb begin
    if (az_q < fdl_q) zone = TZ_FACEDN;
    else if (roll_z > rl) zone = TZ_RIGHT;
    else if (roll_z < -rl) zone = TZ_LEFT;
    else if (pitch_z > pl) zone = TZ_FWD;
    else if (pitch_z < -pl) zone = TZ_BACK;
    else zone = TZ_FLAT;
  end

  logic        out_valid_q;
  logic [27:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_q      <= '0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        if (shake) last_q <= tm_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {active, shake, pitch_t[10:0], roll_t[11:0], zone};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = {4'd0, out_q};
  assign status_o.out_full = out_valid_q && !out_ready_i;

endmodule

@@ sv/atzsd_ctrl.sv @@
// Controller: sequences squares, roots, CORDIC, window sweep and result load.
module atzsd_ctrl
  import atzsd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8,
  parameter int CNT_W        = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  status_t          status_i,
  output cmd_t             cmd_o,
  output logic [CNT_W-1:0] cnt_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q + 1'b1;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_SQR;
        end
      end
      ST_SQR: begin
        if (cnt_q == CNT_W'(SQ_STEPS)) begin
          cmd_o.sqrt_load = 1'b1;
          state_d         = ST_SQRT;
          cnt_d           = '0;
        end else begin
          cmd_o.sq_en = 1'b1;
        end
      end
      ST_SQRT: begin
        if (cnt_q == CNT_W'(SQRT_STEPS)) begin
          cmd_o.cord_load = 1'b1;
          state_d         = ST_CORD;
          cnt_d           = '0;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      ST_CORD: begin
        cmd_o.cord_step = 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_WRITE;
          cnt_d   = '0;
        end
      end
      ST_WRITE: begin
        cmd_o.win_wr  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        state_d       = ST_SWEEP;
        cnt_d         = '0;
      end
      ST_SWEEP: begin
        cmd_o.rd_en  = cnt_q < CNT_W'(WINDOW_DEPTH);
        cmd_o.acc_en = cnt_q != '0;
        if (cnt_q == CNT_W'(WINDOW_DEPTH)) begin
          state_d = ST_PROD;
          cnt_d   = '0;
        end
      end
      ST_PROD: begin
        cmd_o.prod_en = 1'b1;
        state_d       = ST_DONE;
        cnt_d         = '0;
      end
      ST_DONE: begin
        cnt_d = '0;
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  assign cnt_o = cnt_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SQR))
    else $error("accepted sample did not start the square phase");
  a_sqrt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (cnt_q <= CNT_W'(SQRT_STEPS)))
    else $error("root counter overran");
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_full)
    else $error("result loaded over a pending transfer");
  a_done_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !status_i.out_full) |=> (state_q == ST_IDLE))
    else $error("finished item did not return to idle");
`endif

endmodule

@@ sv/accel_tilt_zone_and_shake_detector.sv @@
// Top level of the accelerometer tilt zone and shake detector.
// Input stream s_axis carries one sample per transfer: three signed axis
// counts (8192 = 1 g) and a millisecond timestamp. Output stream m_axis
// carries one result per sample: tilt zone, roll and pitch in tenths of a
// degree, shake and activity flags. Registers are written through cfg_*.
// One sample is worked at a time. From the accepting edge the result passes
// through the squares, two parallel bit-serial square roots, two parallel
// CORDIC lanes, the window write, the sweep over the magnitude window RAM,
// the variance products and the result load before it shows on m_axis. A
// new sample is taken only once the last one has been loaded into the
// result register.
// The result register decouples the sides: a stalled receiver holds only
// the finished result, and the next sample is still taken and worked; the
// block waits at the end of that sample until the register frees up.
// Reset clears the window (valid bits), its pointer, the last shake time,
// the output valid and loads the register defaults; no clearing pass.
module accel_tilt_zone_and_shake_detector
  import atzsd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32], time_ms [79:48]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // zone [2:0], roll_tenths [14:3], pitch_tenths [25:15], shake [26], active [27]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int CW0   = $clog2(WINDOW_DEPTH + 1);
  localparam int CNT_W = (CW0 > 6) ? CW0 : 6;

  cmd_t             cmd;
  status_t          status;
  logic [CNT_W-1:0] cnt;

  atzsd_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .cnt_o      (cnt)
  );

  atzsd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cnt_i       (cnt),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
